// ----- hdl/tlbsa_pkg.sv -----
// Shared types, constants and helper functions of the two-level bitmap slot allocator.
package tlbsa_pkg;

   localparam int WORD_BITS    = 64;
   localparam int WORD_IDX_W   = 6;
   localparam int BITMAP_DEPTH = 64;
   localparam int SLOT_W       = 12;
   localparam int CAP_W        = 13;
   localparam int FWC_W        = 7;

   localparam logic [CAP_W-1:0] MAX_SLOTS = 13'd4096;

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_REBUILD = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_PICK,
      S_LOOKUP,
      S_FIN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic pick;
      logic lookup;
      logic fin;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       rem_ge;
      logic       rec_zero;
      logic       sum_zero;
      logic       lookup_go;
      logic       cand_zero;
      logic       avail_zero;
      logic       out_free;
   } stat_type;

   function automatic logic [WORD_IDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
      logic [WORD_IDX_W-1:0] n;
      n = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) n = WORD_IDX_W'(i);
      end
      return n;
   endfunction

   // Bits of a free word that lie below the capacity.
   function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WORD_IDX_W-1:0] word,
                                                       input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] first;
      logic [CAP_W-1:0] rem;
      first = {1'b0, word, 6'd0};
      rem   = (cap > first) ? (cap - first) : '0;
      if (rem >= CAP_W'(WORD_BITS)) return '1;
      return (64'd1 << rem[WORD_IDX_W-1:0]) - 64'd1;
   endfunction

endpackage

// ----- hdl/tlbsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tlbsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- hdl/tlbsa_ctrl.sv -----
// Sequencing state machine of the slot allocator.
module tlbsa_ctrl import tlbsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output logic     req_ready,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_PREP;
         S_PREP: begin
            if (stat.op == REQ_ALLOC) begin
               if (!stat.rem_ge) state_in = stat.rec_zero ? S_FIN : S_PICK;
            end else begin
               state_in = stat.lookup_go ? S_LOOKUP : S_FIN;
            end
         end
         S_PICK:   state_in = stat.cand_zero ? S_FIN : S_LOOKUP;
         S_LOOKUP: begin
            state_in = (stat.op == REQ_ALLOC && stat.avail_zero) ? S_PICK : S_FIN;
         end
         S_FIN:    state_in = S_OUT;
         S_OUT:    if (stat.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_PREP:   cmd.prep   = 1'b1;
         S_PICK:   cmd.pick   = 1'b1;
         S_LOOKUP: cmd.lookup = 1'b1;
         S_FIN:    cmd.fin    = 1'b1;
         S_OUT:    cmd.out    = stat.out_free;
         default:  cmd        = '0;
      endcase
   end

endmodule

// ----- hdl/tlbsa_dp.sv -----
// Datapath of the slot allocator: bitmaps, counters, word search and result register.
module tlbsa_dp import tlbsa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CAP_W-1:0]        csr_wdata,
   input  logic [1:0]              req_type,
   input  logic [SLOT_W-1:0]       req_slot,
   input  logic                    req_slot_used,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [SLOT_W-1:0]       rsp_slot_out,
   output logic [CAP_W-1:0]        rsp_free_total
);

   logic [CAP_W-1:0]        capacity_ff;
   logic [WORD_BITS-1:0]    summary_ff;
   logic [BITMAP_DEPTH-1:0] valid_ff;
   logic [CAP_W-1:0]        recycled_ff;
   logic [CAP_W-1:0]        bump_ff;
   logic [WORD_IDX_W-1:0]   hint_ff;
   logic [1:0]              op_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic                    used_ff;
   logic [WORD_IDX_W-1:0]   rem_ff;
   logic [WORD_BITS-1:0]    cand_ff;
   logic [WORD_IDX_W-1:0]   word_ff;
   logic                    found_ff;
   logic [1:0]              status_ff;
   logic [SLOT_W-1:0]       slot_out_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [CAP_W-1:0]        rsp_total_ff;

   logic [CAP_W-1:0]      cap_eff;
   logic [CAP_W:0]        cap_round;
   logic [FWC_W-1:0]      fwc;
   logic [WORD_BITS-1:0]  word_lim;
   logic [CAP_W-1:0]      slot_ext;
   logic                  in_range;
   logic                  mark_ok;
   logic [WORD_BITS-1:0]  low_mask;
   logic [WORD_BITS-1:0]  phase0;
   logic [WORD_BITS-1:0]  phase1;
   logic [WORD_IDX_W-1:0] word_pick;
   logic [WORD_IDX_W-1:0] rd_addr;
   logic [WORD_BITS-1:0]  rd_data;
   logic [WORD_BITS-1:0]  word_data;
   logic [WORD_BITS-1:0]  avail;
   logic [WORD_IDX_W-1:0] abit;
   logic [WORD_BITS-1:0]  alloc_next;
   logic [WORD_BITS-1:0]  bit_mask;
   logic                  wr_en;
   logic [WORD_BITS-1:0]  wr_data;
   logic [CAP_W-1:0]      untouched;
   logic [CAP_W:0]        total_sum;
   logic [CAP_W-1:0]      total;

   always_comb begin
      if (capacity_ff == '0)            cap_eff = CAP_W'(1);
      else if (capacity_ff > MAX_SLOTS) cap_eff = MAX_SLOTS;
      else                              cap_eff = capacity_ff;
   end

   assign cap_round = {1'b0, cap_eff} + (CAP_W + 1)'(WORD_BITS - 1);
   assign fwc       = cap_round[CAP_W-1:WORD_IDX_W];
   assign word_lim  = (fwc == FWC_W'(BITMAP_DEPTH)) ? '1
                    : ((64'd1 << fwc[WORD_IDX_W-1:0]) - 64'd1);

   assign slot_ext = {1'b0, slot_ff};
   assign in_range = (slot_ext < cap_eff) && (slot_ext < bump_ff);
   assign mark_ok  = (slot_ext < cap_eff) && !used_ff;

   // Cyclic search: start word and above first, then the words below it.
   assign low_mask  = ~({WORD_BITS{1'b1}} << rem_ff);
   assign phase0    = cand_ff & ~low_mask;
   assign phase1    = cand_ff & low_mask;
   assign word_pick = (|phase0) ? lowest_bit(phase0) : lowest_bit(phase1);
   assign rd_addr   = cmd.pick ? word_pick : slot_ff[SLOT_W-1:WORD_IDX_W];

   tlbsa_ram #(.WIDTH(WORD_BITS), .DEPTH(BITMAP_DEPTH)) u_free_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign word_data  = valid_ff[word_ff] ? rd_data : '0;
   assign avail      = word_data & valid_mask(word_ff, cap_eff);
   assign abit       = lowest_bit(avail);
   assign alloc_next = word_data & ~(64'd1 << abit);
   assign bit_mask   = 64'd1 << slot_ff[WORD_IDX_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_data = word_data | bit_mask;
      if (cmd.lookup) begin
         if (op_ff == REQ_ALLOC) begin
            wr_en   = |avail;
            wr_data = alloc_next;
         end else begin
            wr_en = (word_data & bit_mask) == '0;
         end
      end
   end

   assign untouched = (bump_ff < cap_eff) ? (cap_eff - bump_ff) : '0;
   assign total_sum = {1'b0, untouched} + {1'b0, recycled_ff};
   assign total     = (total_sum > {1'b0, cap_eff}) ? cap_eff : total_sum[CAP_W-1:0];

   always_comb begin
      stat            = '0;
      stat.op         = op_ff;
      stat.rem_ge     = {1'b0, rem_ff} >= fwc;
      stat.rec_zero   = recycled_ff == '0;
      stat.sum_zero   = summary_ff == '0;
      stat.lookup_go  = (op_ff == REQ_RELEASE) ? in_range
                      : (op_ff == REQ_REBUILD) ? mark_ok : 1'b0;
      stat.cand_zero  = cand_ff == '0;
      stat.avail_zero = avail == '0;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= MAX_SLOTS;
         summary_ff   <= '0;
         valid_ff     <= '0;
         recycled_ff  <= '0;
         bump_ff      <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) capacity_ff <= csr_wdata;

         if (cmd.prep && op_ff == REQ_REBUILD && slot_ff == '0) begin
            summary_ff  <= '0;
            valid_ff    <= '0;
            recycled_ff <= '0;
            bump_ff     <= '0;
            hint_ff     <= '0;
         end

         if (cmd.lookup) begin
            if (op_ff == REQ_ALLOC) begin
               if (|avail) begin
                  valid_ff[word_ff] <= 1'b1;
                  recycled_ff       <= recycled_ff - CAP_W'(1);
                  hint_ff           <= word_ff;
                  if (alloc_next == '0) summary_ff[word_ff] <= 1'b0;
               end
            end else if ((word_data & bit_mask) == '0) begin
               valid_ff[word_ff]   <= 1'b1;
               summary_ff[word_ff] <= 1'b1;
               recycled_ff         <= recycled_ff + CAP_W'(1);
            end
         end

         if (cmd.fin) begin
            if (op_ff == REQ_ALLOC && !found_ff && bump_ff < cap_eff) begin
               bump_ff <= bump_ff + CAP_W'(1);
            end
            if (op_ff == REQ_REBUILD && slot_ext + CAP_W'(1) == cap_eff) bump_ff <= cap_eff;
         end

         if (cmd.out)               rsp_valid_ff <= 1'b1;
         else if (rsp_ready)        rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_type;
         slot_ff     <= req_slot;
         used_ff     <= req_slot_used;
         rem_ff      <= hint_ff;
         status_ff   <= ST_OK;
         slot_out_ff <= req_slot;
         found_ff    <= 1'b0;
      end

      if (cmd.prep) begin
         word_ff <= slot_ff[SLOT_W-1:WORD_IDX_W];
         if (op_ff == REQ_ALLOC) begin
            if (stat.rem_ge) rem_ff  <= rem_ff - fwc[WORD_IDX_W-1:0];
            else             cand_ff <= summary_ff & word_lim;
         end
         if (op_ff == REQ_RELEASE && !in_range) status_ff <= ST_REJECT;
      end

      if (cmd.pick) word_ff <= word_pick;

      if (cmd.lookup) begin
         if (op_ff == REQ_ALLOC) begin
            if (|avail) begin
               found_ff    <= 1'b1;
               slot_out_ff <= {word_ff, abit};
            end else begin
               cand_ff[word_ff] <= 1'b0;
            end
         end else if (op_ff == REQ_RELEASE && (word_data & bit_mask) != '0) begin
            status_ff <= ST_REJECT;
         end
      end

      if (cmd.fin && op_ff == REQ_ALLOC && !found_ff) begin
         if (bump_ff < cap_eff) slot_out_ff <= bump_ff[SLOT_W-1:0];
         else                   status_ff   <= ST_FULL;
      end

      if (cmd.out) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= slot_out_ff;
         rsp_total_ff  <= total;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_free_total = rsp_total_ff;

endmodule

// ----- hdl/two_level_bitmap_slot_allocator_top.sv -----
// Top level of the two-level bitmap slot allocator.
//
// Hands out slots 0 .. capacity-1 (capacity written through csr_we/csr_wdata,
// reset value 4096; 0 acts as 1, values above 4096 act as 4096). Recycled slots
// live as set bits in 64 free words of 64 bits held in a RAM, with a 64-bit
// summary of words that may hold free bits. An allocate transaction first
// searches recycled slots starting at the word of the last recycled hit and
// wrapping around, taking the lowest free bit below capacity; failing that it
// hands out the bump pointer, or reports full. A release transaction frees a
// slot below capacity and the bump pointer, and is rejected otherwise or if the
// slot is already free. Rebuild transactions describe a fresh store slot by
// slot: slot 0 clears everything first, the last slot sets the bump pointer to
// capacity. One transaction is in flight at a time. A bump allocation, a full
// report, a release refused on range, a rebuild entry that sets no bit and an
// unknown request type go from preparation straight to finish; a release or
// rebuild entry that reads its free word passes through a lookup step; a
// recycled allocation picks the word, reads it and checks it, repeating this
// for each candidate word holding only bits beyond capacity, and first
// subtracts the word count from the hint until the hint lies below it after
// capacity has shrunk. An allocation that finds free bits only beyond capacity
// rejects each such word before it bumps. The request side reopens as the
// result register loads. The result register lets the next request be
// accepted while a result waits; that next transaction holds at its output
// step until the waiting result is taken.
module two_level_bitmap_slot_allocator_top import tlbsa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CAP_W-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic              req_slot_used,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot_out,
   output logic [CAP_W-1:0]  rsp_free_total
);

   cmd_type  cmd;
   stat_type stat;

   // Sequence each transaction through prepare, search, lookup, finish, output.
   tlbsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Hold bitmaps, counters and the result register.
   tlbsa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_slot       (req_slot),
      .req_slot_used  (req_slot_used),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_free_total (rsp_free_total)
   );

   // One transaction at a time: acceptance closes the input side next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // No recycled slots means no word may be flagged in the summary.
   a_summary_empty: assert property (@(posedge clock) disable iff (reset)
      stat.rec_zero |-> stat.sum_zero)
      else $error("summary bit set with zero recycled count");

   // A new result only appears from the output step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out))
      else $error("result raised outside the output step");

endmodule
